// File: design/elx_pkg.sv
// shared types and constants for the expression lexer
`default_nettype none
package elx_pkg;

	localparam int LINE_BITS   = 16;
	localparam int COLUMN_BITS = 12;
	localparam int LEN_BITS    = 8;
	localparam int KW_BITS     = 3;

	// result queue sizing
	localparam int MAX_PER_ITEM  = 2;
	localparam int FIFO_DEPTH    = 8;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
	// room for the item in the input register plus the one being accepted
	localparam int READY_LEVEL   = FIFO_DEPTH - 2 * MAX_PER_ITEM;

	typedef enum logic [3:0] {
		TK_NUMBER       = 4'd0,
		TK_IDENT        = 4'd1,
		TK_KEYWORD      = 4'd2,
		TK_ADD          = 4'd3,
		TK_SUB          = 4'd4,
		TK_MUL          = 4'd5,
		TK_DIV          = 4'd6,
		TK_LPAREN       = 4'd7,
		TK_RPAREN       = 4'd8,
		TK_MOD          = 4'd9,
		TK_EQUALS       = 4'd10,
		TK_SEMICOLON    = 4'd11,
		TK_END          = 4'd12,
		TK_BAD_BYTE     = 4'd13,
		TK_NO_FRACTION  = 4'd14,
		TK_SECOND_DOT   = 4'd15
	} token_kind_t;

	typedef enum logic [1:0] {
		SC_IDLE  = 2'd0,
		SC_IDENT = 2'd1,
		SC_INT   = 2'd2,
		SC_FRAC  = 2'd3
	} scan_state_t;

	typedef struct packed {
		token_kind_t                kind;
		logic [LINE_BITS-1:0]       line;
		logic [COLUMN_BITS-1:0]     column;
		logic [LEN_BITS-1:0]        length;
		logic [KW_BITS-1:0]         kw_index;
	} token_t;

	// up to two tokens per item, already compacted into tok0 first
	typedef struct packed {
		token_t     tok0;
		token_t     tok1;
		logic [1:0] count;
	} scan_res_t;

	typedef struct packed {
		token_t tok;
		logic   last;
	} fifo_entry_t;

endpackage
`default_nettype wire

// File: design/elx_scanner.sv
// lexer state machine: one byte per cycle, up to two tokens out
`default_nettype none
module elx_scanner (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [7:0]        in_byte,
	input  wire logic              in_end,
	output elx_pkg::scan_res_t     res
);
	import elx_pkg::*;

	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [LEN_BITS-1:0]    LEN_MAX  = '1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

	scan_state_t              st_q, st_d;
	logic [LINE_BITS-1:0]     line_q, line_d;
	logic [COLUMN_BITS-1:0]   col_q, col_d;
	logic [LINE_BITS-1:0]     start_line_q, start_line_d;
	logic [COLUMN_BITS-1:0]   start_col_q, start_col_d;
	logic [LEN_BITS-1:0]      len_q, len_d;
	logic [7:0]               first_q, first_d;

	token_t      tok_a, tok_b;
	logic        a_v, b_v, reproc;
	logic        is_letter, is_digit, is_blank, is_single, kw_hit;
	token_kind_t single_kind;
	logic [KW_BITS-1:0] kw_idx;
	logic [COLUMN_BITS-1:0] col_inc;

	assign is_letter = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
	                   ((in_byte >= 8'h41) && (in_byte <= 8'h5A));
	assign is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
	assign is_blank  = (in_byte == 8'h20) || (in_byte == 8'h09) || (in_byte == 8'h0D) ||
	                   (in_byte == 8'h0B) || (in_byte == 8'h0C);
	assign col_inc   = (col_q == COL_MAX) ? col_q : col_q + 1'b1;

	always_comb begin
		is_single   = 1'b1;
		single_kind = TK_ADD;
		case (in_byte)
			8'h2B: single_kind = TK_ADD;
			8'h2D: single_kind = TK_SUB;
			8'h2A: single_kind = TK_MUL;
			8'h2F: single_kind = TK_DIV;
			8'h28: single_kind = TK_LPAREN;
			8'h29: single_kind = TK_RPAREN;
			8'h25: single_kind = TK_MOD;
			8'h3D: single_kind = TK_EQUALS;
			8'h3B: single_kind = TK_SEMICOLON;
			default: is_single = 1'b0;
		endcase
	end

	// single-letter keywords S R P M C
	always_comb begin
		kw_hit = (len_q == LEN_BITS'(1));
		kw_idx = '0;
		case (first_q)
			8'h53: kw_idx = KW_BITS'(0);
			8'h52: kw_idx = KW_BITS'(1);
			8'h50: kw_idx = KW_BITS'(2);
			8'h4D: kw_idx = KW_BITS'(3);
			8'h43: kw_idx = KW_BITS'(4);
			default: kw_hit = 1'b0;
		endcase
	end

	always_comb begin
		st_d         = st_q;
		line_d       = line_q;
		col_d        = col_q;
		start_line_d = start_line_q;
		start_col_d  = start_col_q;
		len_d        = len_q;
		first_d      = first_q;
		tok_a        = '0;
		tok_b        = '0;
		a_v          = 1'b0;
		b_v          = 1'b0;
		reproc       = 1'b0;

		tok_a.line   = start_line_q;
		tok_a.column = start_col_q;
		tok_a.length = len_q;

		// first pass: extend or close the open lexeme
		case (st_q)
			SC_IDENT: begin
				if (!in_end && (is_letter || is_digit)) begin
					len_d = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;
					col_d = col_inc;
				end else begin
					a_v            = 1'b1;
					tok_a.kind     = kw_hit ? TK_KEYWORD : TK_IDENT;
					tok_a.kw_index = kw_hit ? kw_idx : '0;
					reproc         = 1'b1;
				end
			end
			SC_INT: begin
				if (!in_end && (is_digit || in_byte == CH_DOT)) begin
					len_d = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;
					col_d = col_inc;
					if (!is_digit) begin
						st_d = SC_FRAC;
					end
				end else begin
					a_v        = 1'b1;
					tok_a.kind = TK_NO_FRACTION;
					reproc     = 1'b1;
				end
			end
			SC_FRAC: begin
				if (!in_end && is_digit) begin
					len_d = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;
					col_d = col_inc;
				end else begin
					a_v        = 1'b1;
					tok_a.kind = (!in_end && in_byte == CH_DOT) ? TK_SECOND_DOT : TK_NUMBER;
					reproc     = 1'b1;
				end
			end
			default: begin
				reproc = 1'b1;
			end
		endcase

		// second pass from idle; position is unchanged by a closing lexeme
		if (reproc) begin
			st_d         = SC_IDLE;
			tok_b.line   = line_q;
			tok_b.column = col_q;
			tok_b.length = LEN_BITS'(1);
			if (in_end) begin
				b_v          = 1'b1;
				tok_b.kind   = TK_END;
				tok_b.length = '0;
			end else if (is_letter || is_digit || in_byte == CH_DOT) begin
				st_d         = is_letter ? SC_IDENT : (is_digit ? SC_INT : SC_FRAC);
				start_line_d = line_q;
				start_col_d  = col_q;
				len_d        = LEN_BITS'(1);
				first_d      = in_byte;
				col_d        = col_inc;
			end else if (is_single) begin
				b_v        = 1'b1;
				tok_b.kind = single_kind;
				col_d      = col_inc;
			end else if (in_byte == CH_NL) begin
				line_d = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
				col_d  = '0;
			end else if (is_blank) begin
				col_d = col_inc;
			end else begin
				b_v        = 1'b1;
				tok_b.kind = TK_BAD_BYTE;
				col_d      = col_inc;
			end
		end

		res.tok0  = a_v ? tok_a : tok_b;
		res.tok1  = tok_b;
		res.count = in_valid ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= SC_IDLE;
			line_q       <= LINE_BITS'(1);
			col_q        <= '0;
			start_line_q <= '0;
			start_col_q  <= '0;
			len_q        <= '0;
			first_q      <= '0;
		end else if (in_valid) begin
			st_q         <= st_d;
			line_q       <= line_d;
			col_q        <= col_d;
			start_line_q <= start_line_d;
			start_col_q  <= start_col_d;
			len_q        <= len_d;
			first_q      <= first_d;
		end
	end

endmodule
`default_nettype wire

// File: design/elx_out_fifo.sv
// result queue: takes up to two tokens a cycle, gives one
`default_nettype none
module elx_out_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire elx_pkg::scan_res_t            push,
	input  wire logic                          pop,
	output elx_pkg::fifo_entry_t               head,
	output logic                               not_empty,
	output logic [elx_pkg::FIFO_CNT_BITS-1:0]  level
);
	import elx_pkg::*;

	fifo_entry_t              mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [FIFO_CNT_BITS-1:0] cnt_q;
	logic                     do_pop;

	assign not_empty = (cnt_q != '0);
	assign level     = cnt_q;
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= '{tok: push.tok0, last: (push.count == 2'd1)};
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_p1] <= '{tok: push.tok1, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(push.count);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(do_pop);
		end
	end

endmodule
`default_nettype wire

// File: design/expression_lexer_dfa.sv
// top level of the calculator expression lexer
//
// usage: feed source text one byte per item on the s_ side; set s_tlast with
// an item to mark end of input (its byte is ignored, an end token is produced).
// tokens leave on the m_ side, one per item, m_tlast set on the last token
// caused by an input item; an input byte causes zero, one or two tokens.
// path: an accepted byte is held in the input register, the lexer's logic is
// combinational between that register and the token queue, and all tokens of
// a byte are written into the queue together; a second token from the same
// byte leaves once the first is taken.
// throughput: one byte every cycle while the token queue has room; the queue
// drains one token per cycle while the receiver is ready.
// the 8-entry token queue absorbs two tokens per byte; s_tready drops when
// fewer than four entries are free, so a stalled receiver backs up into the
// source and no token is lost.
// reset: asynchronous, empties the queue, clears the input register's valid flag
// and puts the lexer idle at line 1, column 0.
`default_nettype none
module expression_lexer_dfa (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
	input  wire logic        s_tlast,   // end_of_input
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [3:0] token_kind, [19:4] token_line, [31:20] token_column,
	// [39:32] lexeme_length, [42:40] keyword_index, [47:43] zero
	output logic [47:0]      m_tdata,
	output logic             m_tlast    // last_of_run
);
	import elx_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;

	scan_res_t                scan_res;
	fifo_entry_t              head;
	logic                     fifo_not_empty;
	logic [FIFO_CNT_BITS-1:0] fifo_level;

	// worst case: item in s1 and the new item each add two tokens
	assign s_tready = (fifo_level <= FIFO_CNT_BITS'(READY_LEVEL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	// byte payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	elx_scanner u_scanner (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_byte  (byte_s1),
		.in_end   (end_s1),
		.res      (scan_res)
	);

	elx_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (scan_res),
		.pop       (m_tready),
		.head      (head),
		.not_empty (fifo_not_empty),
		.level     (fifo_level)
	);

	// token fields packed from the low bit up
	assign m_tvalid = fifo_not_empty;
	assign m_tdata  = {5'd0, head.tok.kw_index, head.tok.length, head.tok.column,
	                   head.tok.line, head.tok.kind};
	assign m_tlast  = head.last;

endmodule
`default_nettype wire

// File: tb/sv/tb_expression_lexer_dfa.sv
// self-checking testbench for the expression lexer: byte stream in, checked token stream out
`default_nettype none
module tb_expression_lexer_dfa;
	timeunit 1ns;
	timeprecision 1ps;

	import elx_pkg::*;

	// source byte codes that have no printable form
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;

	// keyword letters, slot 0 in the lowest byte: S R P M C
	localparam int         KEYWORD_COUNT = 5;
	localparam logic [39:0] KEYWORD_CHARS = "CMPRS";

	localparam int MAX_GAP      = 4;
	localparam int REPORT_LIMIT = 10;
	localparam int CYCLE_LIMIT  = 3000000;

	// one token as it should leave the block, with its end-of-item flag
	typedef struct packed {
		token_t tok;
		logic   last;
	} lexed_token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] char_byte
	logic        s_tlast = 1'b0;    // end_of_input
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [3:0] token_kind, [19:4] token_line, [31:20] token_column,
	// [39:32] lexeme_length, [42:40] keyword_index, [47:43] zero
	logic [47:0] m_tdata;
	logic        m_tlast;           // last_of_run

	// tokens still owed by the block, oldest first
	lexed_token_t expected_tokens[$];
	// tokens caused by the item being lexed right now
	lexed_token_t step_tokens[$];

	// shadow lexer state
	scan_state_t            lx_state = SC_IDLE;
	logic [LINE_BITS-1:0]   lx_line = LINE_BITS'(1);
	logic [COLUMN_BITS-1:0] lx_col = '0;
	logic [LINE_BITS-1:0]   lx_start_line = '0;
	logic [COLUMN_BITS-1:0] lx_start_col = '0;
	logic [LEN_BITS-1:0]    lx_len = '0;
	logic [7:0]             lx_first = '0;

	int items_sent = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	// per-item random gaps on the source and sink side
	bit idle_src = 1'b1;
	bit idle_sink = 1'b1;
	// sink wait drawn after each token, and a long hold-off on request
	int sink_wait = 0;
	int hold_cycles = 0;

	expression_lexer_dfa u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("expression_lexer_dfa test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// shadow lexer
	// ---------------------------------------------------------------

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == " " || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
	endfunction

	// kind of a one-byte token; number stands for "not one of them"
	function automatic token_kind_t punct_kind(input logic [7:0] c);
		case (c)
			"+": return TK_ADD;
			"-": return TK_SUB;
			"*": return TK_MUL;
			"/": return TK_DIV;
			"(": return TK_LPAREN;
			")": return TK_RPAREN;
			"%": return TK_MOD;
			"=": return TK_EQUALS;
			";": return TK_SEMICOLON;
			default: return TK_NUMBER;
		endcase
	endfunction

	// column saturates at the top of its range
	function automatic void step_column();
		if (lx_col != '1)
			lx_col = lx_col + 1'b1;
	endfunction

	function automatic void add_token(input token_kind_t kind,
			input logic [LINE_BITS-1:0] line, input logic [COLUMN_BITS-1:0] col,
			input logic [LEN_BITS-1:0] len, input logic [KW_BITS-1:0] kw);
		lexed_token_t t;
		t.tok.kind = kind;
		t.tok.line = line;
		t.tok.column = col;
		t.tok.length = len;
		t.tok.kw_index = kw;
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void start_lexeme(input scan_state_t st, input logic [7:0] c);
		lx_state = st;
		lx_start_line = lx_line;
		lx_start_col = lx_col;
		lx_len = LEN_BITS'(1);
		lx_first = c;
		step_column();
	endfunction

	// lexeme length saturates at 255
	function automatic void grow_lexeme();
		if (lx_len != '1)
			lx_len = lx_len + 1'b1;
		step_column();
	endfunction

	// slot of a one-letter keyword, KEYWORD_COUNT when the lexeme is a plain name
	function automatic int keyword_slot();
		if (lx_len != LEN_BITS'(1))
			return KEYWORD_COUNT;
		for (int k = 0; k < KEYWORD_COUNT; k++)
			if (lx_first == KEYWORD_CHARS[8*k +: 8])
				return k;
		return KEYWORD_COUNT;
	endfunction

	// one pass over a byte or end mark; 1 when the byte ended a lexeme
	// and has to be looked at again from idle
	function automatic bit lex_pass(input logic [7:0] c, input logic eoi);
		token_kind_t op;
		int kw;
		case (lx_state)
			SC_IDENT: begin
				if (!eoi && (is_letter(c) || is_digit(c))) begin
					grow_lexeme();
					return 1'b0;
				end
				kw = keyword_slot();
				if (kw < KEYWORD_COUNT)
					add_token(TK_KEYWORD, lx_start_line, lx_start_col, lx_len, 3'(kw));
				else
					add_token(TK_IDENT, lx_start_line, lx_start_col, lx_len, '0);
				lx_state = SC_IDLE;
				return 1'b1;
			end
			SC_INT: begin
				if (!eoi && is_digit(c)) begin
					grow_lexeme();
					return 1'b0;
				end
				if (!eoi && c == ".") begin
					grow_lexeme();
					lx_state = SC_FRAC;
					return 1'b0;
				end
				// digits with no dot at all
				add_token(TK_NO_FRACTION, lx_start_line, lx_start_col, lx_len, '0);
				lx_state = SC_IDLE;
				return 1'b1;
			end
			SC_FRAC: begin
				if (!eoi && is_digit(c)) begin
					grow_lexeme();
					return 1'b0;
				end
				// a second dot closes the lexeme as an error and starts a new number
				add_token((!eoi && c == ".") ? TK_SECOND_DOT : TK_NUMBER,
					lx_start_line, lx_start_col, lx_len, '0);
				lx_state = SC_IDLE;
				return 1'b1;
			end
			default: begin
				lx_state = SC_IDLE;
				if (eoi) begin
					// end token sits at the current position and takes no column
					add_token(TK_END, lx_line, lx_col, '0, '0);
					return 1'b0;
				end
				if (is_letter(c)) begin
					start_lexeme(SC_IDENT, c);
					return 1'b0;
				end
				if (is_digit(c)) begin
					start_lexeme(SC_INT, c);
					return 1'b0;
				end
				// a leading dot already makes a number
				if (c == ".") begin
					start_lexeme(SC_FRAC, c);
					return 1'b0;
				end
				op = punct_kind(c);
				if (op != TK_NUMBER) begin
					add_token(op, lx_line, lx_col, LEN_BITS'(1), '0);
					step_column();
					return 1'b0;
				end
				if (c == CH_LF) begin
					if (lx_line != '1)
						lx_line = lx_line + 1'b1;
					lx_col = '0;
					return 1'b0;
				end
				if (is_blank(c)) begin
					step_column();
					return 1'b0;
				end
				// anything else, high bytes included, is consumed as a bad byte
				add_token(TK_BAD_BYTE, lx_line, lx_col, LEN_BITS'(1), '0);
				step_column();
				return 1'b0;
			end
		endcase
	endfunction

	// lexes one accepted item and queues the tokens it owes
	function automatic void lex_item(input logic [7:0] c, input logic eoi);
		lexed_token_t t;
		step_tokens.delete();
		if (lex_pass(c, eoi))
			void'(lex_pass(c, eoi));
		if (step_tokens.size() > 0) begin
			t = step_tokens.pop_back();
			t.last = 1'b1;
			step_tokens.push_back(t);
		end
		while (step_tokens.size() > 0)
			expected_tokens.push_back(step_tokens.pop_front());
	endfunction

	// ---------------------------------------------------------------
	// source side
	// ---------------------------------------------------------------

	// offers one item after a random gap and waits for the handshake;
	// valid stays up only until the next falling edge
	task automatic send_char(input logic [7:0] c, input logic eoi);
		int gap;
		gap = idle_src ? $urandom_range(0, MAX_GAP) : 0;
		@(negedge clk);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eoi;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		lex_item(c, eoi);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	function automatic logic [7:0] pick_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	// ---------------------------------------------------------------
	// sink side
	// ---------------------------------------------------------------

	// ready drops for the long hold-off first, then for the per-token wait
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else if (sink_wait > 0) begin
			sink_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic check_token(input logic [47:0] data, input logic last);
		lexed_token_t want;
		token_t got;
		bit bad;
		got.kind = token_kind_t'(data[3:0]);
		got.line = data[19:4];
		got.column = data[31:20];
		got.length = data[39:32];
		got.kw_index = data[42:40];
		if (expected_tokens.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: token with none owed: kind %0d line %0d col %0d len %0d kw %0d last %0b",
					$realtime, got.kind, got.line, got.column, got.length, got.kw_index, last);
			return;
		end
		want = expected_tokens.pop_front();
		bad = (got.kind !== want.tok.kind) || (got.line !== want.tok.line) ||
			(got.column !== want.tok.column) || (got.length !== want.tok.length) ||
			(got.kw_index !== want.tok.kw_index) || (last !== want.last);
		if (bad) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT) begin
				$display("%0t: token mismatch", $realtime);
				$display("  expected kind %0d line %0d col %0d len %0d kw %0d last %0b",
					want.tok.kind, want.tok.line, want.tok.column, want.tok.length,
					want.tok.kw_index, want.last);
				$display("  actual   kind %0d line %0d col %0d len %0d kw %0d last %0b",
					got.kind, got.line, got.column, got.length, got.kw_index, last);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			check_token(m_tdata, m_tlast);
			sink_wait = idle_sink ? $urandom_range(0, MAX_GAP) : 0;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// every operator, keyword vs name, a lone dot, an integer cut short,
	// bad bytes at both ends of the range and an end mark with a junk byte
	task automatic test_directed_tokens();
		idle_src = 1'b1;
		idle_sink = 1'b1;
		send_text("M=1.5*(x2-.)/9+%;");
		send_char(8'hFF, 1'b0);
		send_char(CH_NUL, 1'b0);
		send_char(CH_LF, 1'b0);
		send_char(8'h80, 1'b1);
	endtask

	// second dot, trailing dot, every blank, and lexemes closed by the end mark
	task automatic test_number_edges();
		send_text("12.3.");
		send_char(CH_TAB, 1'b0);
		send_char(CH_CR, 1'b0);
		send_char(CH_VT, 1'b0);
		send_char(CH_FF, 1'b0);
		send_text("7.C");
		send_char(CH_NUL, 1'b1);
		send_text(" R9 4");
		send_char(8'hA5, 1'b1);
	endtask

	// mostly well-formed source text with random content; the rest is
	// broken numbers, end marks and raw random bytes
	task automatic test_random_text(input int goal, input bit src_gaps, input bit sink_gaps);
		int first_item;
		int pick;
		string op_chars;
		string kw_chars;
		first_item = items_sent;
		op_chars = "+-*/()%=;";
		kw_chars = "SRPMC";
		idle_src = src_gaps;
		idle_sink = sink_gaps;
		while (items_sent - first_item < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				// name of random letters and digits
				send_char(pick_letter(), 1'b0);
				repeat ($urandom_range(0, 5))
					send_char(($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter(), 1'b0);
			end else if (pick < 28) begin
				send_char(kw_chars[$urandom_range(0, 4)], 1'b0);
			end else if (pick < 45) begin
				// number, possibly with no integer or no fraction digits
				repeat ($urandom_range(0, 3))
					send_char(pick_digit(), 1'b0);
				send_char(".", 1'b0);
				repeat ($urandom_range(0, 3))
					send_char(pick_digit(), 1'b0);
			end else if (pick < 63) begin
				send_char(op_chars[$urandom_range(0, 8)], 1'b0);
			end else if (pick < 76) begin
				case ($urandom_range(0, 4))
					0: send_char(" ", 1'b0);
					1: send_char(CH_TAB, 1'b0);
					2: send_char(CH_CR, 1'b0);
					3: send_char(CH_VT, 1'b0);
					default: send_char(CH_FF, 1'b0);
				endcase
			end else if (pick < 81) begin
				send_char(CH_LF, 1'b0);
			end else if (pick < 84) begin
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end else if (pick < 91) begin
				// integer with no dot, or a number with a second dot
				repeat ($urandom_range(1, 3))
					send_char(pick_digit(), 1'b0);
				if ($urandom_range(0, 1)) begin
					send_char(".", 1'b0);
					repeat ($urandom_range(0, 2))
						send_char(pick_digit(), 1'b0);
					send_char(".", 1'b0);
				end
			end else begin
				send_char(8'($urandom_range(0, 255)), 1'b0);
			end
			// a separator now and then keeps lexemes from running together
			if ($urandom_range(0, 1))
				send_char(" ", 1'b0);
		end
	endtask

	// sink holds off for a long stretch while the source keeps offering,
	// two tokens per second item, so the token queue fills and input stalls
	task automatic test_receiver_hold();
		idle_src = 1'b0;
		idle_sink = 1'b0;
		hold_cycles = 150;
		repeat (30) begin
			send_char("k", 1'b0);
			send_char("*", 1'b0);
		end
		idle_src = 1'b1;
		idle_sink = 1'b1;
	endtask

	// lexeme length stops at 255 for names, numbers and bare integers
	task automatic test_long_lexemes();
		repeat (300)
			send_char("q", 1'b0);
		send_char(" ", 1'b0);
		repeat (270)
			send_char("9", 1'b0);
		send_char(".", 1'b0);
		repeat (5)
			send_char("1", 1'b0);
		send_char(";", 1'b0);
		repeat (260)
			send_char("6", 1'b0);
		send_char(CH_LF, 1'b0);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_tokens();
		test_number_edges();
		test_random_text(200, 1'b1, 1'b1);
		test_random_text(200, 1'b0, 1'b0);
		test_random_text(200, 1'b1, 1'b0);
		test_random_text(200, 1'b0, 1'b1);
		test_receiver_hold();
		test_long_lexemes();

		@(negedge clk);
		s_tvalid <= 1'b0;
		// the watchdog bounds this wait
		while (expected_tokens.size() != 0)
			@(posedge clk);
		// a further wait to catch anything the block should not send
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_tokens.size() == 0)
			$display("expression_lexer_dfa test passed");
		else
			$display("expression_lexer_dfa test failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
design/elx_pkg.sv
design/elx_scanner.sv
design/elx_out_fifo.sv
design/expression_lexer_dfa.sv
tb/sv/tb_expression_lexer_dfa.sv
